// ===== src/mcrfe_pkg.sv =====
// Shared types, constants and the field width table for the modem cell
// report field extractor. No dependencies.
package mcrfe_pkg;

  localparam logic [7:0] COLON_CHAR = 8'h3A;
  localparam logic [7:0] COMMA_CHAR = 8'h2C;

  localparam logic [2:0] FIELD_CHANNEL = 3'd5;
  localparam logic [2:0] FIELD_RSSI    = 3'd6;

  typedef enum logic [1:0] {
    PH_WAIT    = 2'd0,
    PH_SKIP    = 2'd1,
    PH_EXTRACT = 2'd2,
    PH_SWALLOW = 2'd3
  } phase_e;

  typedef enum logic {
    EV_CHAR  = 1'b0,
    EV_CLEAR = 1'b1
  } event_kind_e;

  // One result item plus a flag telling whether the step produced it.
  typedef struct packed {
    logic        hit;
    event_kind_e kind;
    logic [2:0]  field_index;
    logic [1:0]  char_position;
    logic [7:0]  char_value;
  } evt_t;

  function automatic logic [2:0] field_width(input logic [2:0] f);
    logic [2:0] w;
    case (f)
      3'd0:    w = 3'd3;
      3'd1:    w = 3'd3;
      3'd2:    w = 3'd4;
      3'd3:    w = 3'd4;
      3'd4:    w = 3'd3;
      3'd5:    w = 3'd3;
      3'd6:    w = 3'd2;
      default: w = 3'd0;
    endcase
    return w;
  endfunction

endpackage

// ===== src/mcrfe_in_if.sv =====
// Input byte channel: valid/ready handshake carrying one received byte.
// No dependencies.
interface mcrfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== src/mcrfe_out_if.sv =====
// Result channel: valid/ready handshake carrying one extracted event item.
// No dependencies.
interface mcrfe_out_if;
  logic       valid;
  logic       ready;
  logic       event_kind;
  logic [2:0] field_index;
  logic [1:0] char_position;
  logic [7:0] char_value;

  modport source (output valid, output event_kind, output field_index,
                  output char_position, output char_value, input ready);
  modport sink   (input valid, input event_kind, input field_index,
                  input char_position, input char_value, output ready);
endinterface

// ===== src/modem_cell_report_field_extractor_top.sv =====
// The result item of an accepted byte is registered and shows on out_o in the next cycle.
// Throughput: one byte per cycle while out_o takes each result; the output
// register frees as it is taken, so a byte is accepted in the same cycle
// the previous result is consumed. Bytes with no result still advance the parser.
// Reset (rst_ni low, async): parser waits for a colon, skip_commas = 0,
// no result pending.
module modem_cell_report_field_extractor_top
  import mcrfe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [5:0] cfg_wdata_i,
  mcrfe_in_if.sink   in_i,
  mcrfe_out_if.source out_o
);

  logic [5:0] skip_q;
  logic       out_valid_q;
  evt_t       evt;
  evt_t       res_q;
  logic       accept;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q <= '0;
    end else if (cfg_we_i) begin
      skip_q <= cfg_wdata_i;
    end
  end

  mcrfe_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (accept),
    .byte_i        (in_i.rx_byte),
    .skip_commas_i (skip_q),
    .evt_o         (evt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= accept && evt.hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && evt.hit) begin
      res_q <= evt;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.event_kind    = res_q.kind;
  assign out_o.field_index   = res_q.field_index;
  assign out_o.char_position = res_q.char_position;
  assign out_o.char_value    = res_q.char_value;

endmodule

// ===== src/mcrfe_core.sv =====
// Parser state and per-byte step logic of the field extractor.
// Depends on mcrfe_pkg.
module mcrfe_core
  import mcrfe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic [5:0] skip_commas_i,
  output evt_t       evt_o
);

  phase_e     phase_q, phase_d;
  logic [5:0] commas_q, commas_d;
  logic [2:0] field_q, field_d;
  logic [2:0] chars_q, chars_d;

  logic [5:0] commas_inc;
  logic [2:0] chars_inc;
  logic [2:0] field_inc;
  logic       is_comma;

  assign commas_inc = commas_q + 6'd1;
  assign chars_inc  = chars_q + 3'd1;
  assign field_inc  = field_q + 3'd1;
  assign is_comma   = (byte_i == COMMA_CHAR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_WAIT;
      commas_q <= '0;
      field_q  <= '0;
      chars_q  <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      commas_q <= commas_d;
      field_q  <= field_d;
      chars_q  <= chars_d;
    end
  end

  always_comb begin
    logic       enter;
    logic [2:0] enter_field;
    enter       = 1'b0;
    enter_field = '0;
    phase_d     = phase_q;
    commas_d    = commas_q;
    field_d     = field_q;
    chars_d     = chars_q;
    evt_o       = '{hit: 1'b0, kind: EV_CHAR, field_index: '0,
                    char_position: '0, char_value: '0};

    case (phase_q)
      PH_WAIT: begin
        if (byte_i == COLON_CHAR) begin
          commas_d = '0;
          if (skip_commas_i == '0) begin
            enter = 1'b1;
          end else begin
            phase_d = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        if (is_comma) begin
          commas_d = commas_inc;
          if (commas_inc == skip_commas_i) begin
            enter = 1'b1;
          end
        end
      end
      PH_EXTRACT: begin
        if (field_q > FIELD_RSSI) begin
          phase_d = PH_WAIT;
        end else if (is_comma) begin
          if (field_q == FIELD_RSSI) begin
            phase_d = PH_WAIT;
          end else begin
            enter       = 1'b1;
            enter_field = field_inc;
          end
        end else begin
          evt_o = '{hit: 1'b1, kind: EV_CHAR, field_index: field_q,
                    char_position: chars_q[1:0], char_value: byte_i};
          chars_d = chars_inc;
          if (chars_inc >= field_width(field_q)) begin
            phase_d = (field_q == FIELD_RSSI) ? PH_WAIT : PH_SWALLOW;
          end
        end
      end
      PH_SWALLOW: begin
        // byte after a full field is taken as its separator
        if (field_q >= FIELD_RSSI) begin
          phase_d = PH_WAIT;
        end else begin
          enter       = 1'b1;
          enter_field = field_inc;
        end
      end
      default: begin
        phase_d = PH_WAIT;
      end
    endcase

    if (enter) begin
      field_d = enter_field;
      chars_d = '0;
      phase_d = PH_EXTRACT;
      if (enter_field == FIELD_CHANNEL || enter_field == FIELD_RSSI) begin
        evt_o = '{hit: 1'b1, kind: EV_CLEAR, field_index: enter_field,
                  char_position: '0, char_value: '0};
      end
    end
  end

  a_clear_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (evt_o.hit && evt_o.kind == EV_CLEAR) |->
      ((evt_o.field_index == FIELD_CHANNEL || evt_o.field_index == FIELD_RSSI)
       && evt_o.char_position == 2'd0 && evt_o.char_value == 8'd0))
    else $error("clear event on wrong field or with payload");

  a_chars_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_EXTRACT) |-> (chars_q < field_width(field_q)))
    else $error("field character count beyond field width");

  a_swallow_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SWALLOW) |-> (field_q < FIELD_RSSI &&
                                 chars_q == field_width(field_q)))
    else $error("separator swallow outside a full non-final field");

  a_field_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && evt_o.hit) |=> (field_q <= FIELD_RSSI))
    else $error("field index left the valid range");

endmodule
